// File: sv/pfpm_pkg.sv
// Package: shared types and constants of the page frame pool manager
package pfpm_pkg;

  localparam int NumFramesDef = 8;
  localparam int PageBitsDef  = 24;
  localparam int MaxFlush     = 8;

  typedef enum logic [2:0] {
    CMD_PIN    = 3'd0,
    CMD_UNPIN  = 3'd1,
    CMD_DIRTY  = 3'd2,
    CMD_FORCE  = 3'd3,
    CMD_FLUSH  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_ALL_PIN  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_OUT,
    S_FLUSH
  } state_t;

  localparam logic [0:0] REG_MODE   = 1'd0;
  localparam logic [0:0] REG_FRAMES = 1'd1;

  // operation applied by a selected cell in the action cycle or a flush step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PIN,
    OP_UNPIN,
    OP_DIRTY,
    OP_CLEAN,
    OP_LOAD
  } op_t;

endpackage

// File: sv/page_frame_pool_manager.sv
// Top level: frame table of a page buffer pool with FIFO/LRU replacement
// Usage: one request (cmd, page_number) enters on the in channel when
// in_valid is high and in_stall low. Lookup and victim choice ripple along a
// row of registered frame cells, one cell per cycle, so the result of a
// pin, unpin, mark dirty or force page request is registered after the
// scan and action states; one request is handled at a time. Flush walks
// the managed frames one per cycle while results are taken and gives one
// result per dirty unpinned frame, or a single result with no writeback
// when there is none; last marks the final result of a request.
// out_stall holds the result register and pauses the flush walk; no new
// request is taken until the current one's results have all gone. Reset
// empties every frame, sets ranks to index order, clears the counters,
// selects FIFO and 8 frames.
// Configuration must be written over the APB port only while idle; the block does not enforce this.
module page_frame_pool_manager #(
  parameter int NUM_FRAMES = pfpm_pkg::NumFramesDef,
  parameter int PAGE_BITS  = pfpm_pkg::PageBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [PAGE_BITS-1:0] page_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [2:0]           frame_index,
  output logic                 fetch,
  output logic                 writeback,
  output logic [PAGE_BITS-1:0] writeback_page,
  output logic [31:0]          read_count,
  output logic [31:0]          write_count,
  output logic                 last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int IB = $clog2(NUM_FRAMES);
  localparam int CB = $clog2(NUM_FRAMES + 1);

  logic       mode;
  logic [3:0] frames_reg;
  logic [CB:0] n_managed;

  pfpm_pkg::state_t state, state_next;
  logic [2:0]            cmd_q;
  logic [PAGE_BITS-1:0]  key;
  logic [CB-1:0]         cnt;
  logic [31:0]           reads_done, writes_done;

  // chain wires
  logic [NUM_FRAMES:0]   hit_c, empty_c, cand_c;
  logic [IB-1:0]         hit_i [NUM_FRAMES+1];
  logic [IB-1:0]         empty_i [NUM_FRAMES+1];
  logic [IB-1:0]         cand_i [NUM_FRAMES+1];
  logic [IB-1:0]         cand_r [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]  pg [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] vl, dt, pn;
  logic [IB-1:0]         rk [NUM_FRAMES];

  logic [NUM_FRAMES-1:0] sel;
  pfpm_pkg::op_t         op;
  logic                  age_upd;
  logic [IB-1:0]         age_ref;
  logic                  scan;
  logic [IB-1:0]         fidx;
  logic [CB-1:0]         flush_done;
  logic                  flush_hit;
  logic                  more_after;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pfpm_pkg::REG_FRAMES) ? {28'd0, frames_reg} : {31'd0, mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      frames_reg <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == pfpm_pkg::REG_MODE) mode <= pwdata[0];
      else frames_reg <= pwdata[3:0];
    end
  end

  always_comb begin
    if (frames_reg == 4'd0) n_managed = (CB+1)'(1);
    else if ({1'b0, frames_reg} > 5'(NUM_FRAMES)) n_managed = (CB+1)'(NUM_FRAMES);
    else n_managed = (CB+1)'(frames_reg);
  end

  assign scan = (state == pfpm_pkg::S_SCAN);

  assign hit_c[0]   = 1'b0;
  assign empty_c[0] = 1'b0;
  assign cand_c[0]  = 1'b0;
  assign hit_i[0]   = '0;
  assign empty_i[0] = '0;
  assign cand_i[0]  = '0;
  assign cand_r[0]  = '0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    pfpm_cell #(.PageBits(PAGE_BITS), .IdxBits(IB)) u_cell (
      .clk, .rst,
      .my_index(IB'(g)),
      .managed((CB+1)'(g) < n_managed),
      .key, .scan,
      .hit_in(hit_c[g]), .hit_idx_in(hit_i[g]),
      .empty_in(empty_c[g]), .empty_idx_in(empty_i[g]),
      .cand_in(cand_c[g]), .cand_idx_in(cand_i[g]), .cand_rank_in(cand_r[g]),
      .hit_out(hit_c[g+1]), .hit_idx_out(hit_i[g+1]),
      .empty_out(empty_c[g+1]), .empty_idx_out(empty_i[g+1]),
      .cand_out(cand_c[g+1]), .cand_idx_out(cand_i[g+1]),
      .cand_rank_out(cand_r[g+1]),
      .sel(sel[g]), .op, .age_upd, .age_ref,
      .page(pg[g]), .valid(vl[g]), .dirty(dt[g]), .pinned(pn[g]), .rank(rk[g])
    );
  end

  logic hit, found;
  logic [IB-1:0] tgt;
  assign hit   = hit_c[NUM_FRAMES];
  assign found = hit || empty_c[NUM_FRAMES] || cand_c[NUM_FRAMES];
  assign tgt   = hit ? hit_i[NUM_FRAMES] :
                 (empty_c[NUM_FRAMES] ? empty_i[NUM_FRAMES] : cand_i[NUM_FRAMES]);

  assign in_stall = (state != pfpm_pkg::S_IDLE) || out_valid;
  assign fidx = cnt[IB-1:0];
  assign flush_done = CB'(n_managed);
  assign flush_hit = vl[fidx] && dt[fidx] && !pn[fidx];

  // another flush result still to come above the current frame
  always_comb begin
    more_after = 1'b0;
    for (int g = 0; g < NUM_FRAMES; g++) begin
      if (g > int'(fidx) && (CB+1)'(g) < n_managed && vl[g] && dt[g] && !pn[g])
        more_after = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pfpm_pkg::S_IDLE:
        if (in_valid && !in_stall) begin
          if (cmd == pfpm_pkg::CMD_FLUSH) state_next = pfpm_pkg::S_FLUSH;
          else state_next = pfpm_pkg::S_SCAN;
        end
      pfpm_pkg::S_SCAN:
        if (cnt == CB'(NUM_FRAMES - 1)) state_next = pfpm_pkg::S_ACT;
      pfpm_pkg::S_ACT: state_next = pfpm_pkg::S_IDLE;
      pfpm_pkg::S_FLUSH:
        if (!out_valid || !out_stall) begin
          if (cnt == flush_done - 1'b1) state_next = pfpm_pkg::S_IDLE;
        end
      default: state_next = pfpm_pkg::S_IDLE;
    endcase
  end

  // action and flush decode for the cells
  always_comb begin
    sel = '0;
    op = pfpm_pkg::OP_NONE;
    age_upd = 1'b0;
    age_ref = '0;
    if (state == pfpm_pkg::S_ACT) begin
      age_ref = rk[tgt];
      case (cmd_q)
        pfpm_pkg::CMD_PIN: if (found) begin
          sel[tgt] = 1'b1;
          op = hit ? pfpm_pkg::OP_PIN : pfpm_pkg::OP_LOAD;
          age_upd = !hit || mode;
        end
        pfpm_pkg::CMD_UNPIN: if (hit) begin
          sel[tgt] = 1'b1; op = pfpm_pkg::OP_UNPIN;
        end
        pfpm_pkg::CMD_DIRTY: if (hit) begin
          sel[tgt] = 1'b1; op = pfpm_pkg::OP_DIRTY;
        end
        pfpm_pkg::CMD_FORCE: if (hit && dt[tgt] && !pn[tgt]) begin
          sel[tgt] = 1'b1; op = pfpm_pkg::OP_CLEAN;
        end
        default: ;
      endcase
    end else if (state == pfpm_pkg::S_FLUSH && (!out_valid || !out_stall) &&
                 (CB+1)'(cnt) < n_managed && flush_hit) begin
      sel[fidx] = 1'b1; op = pfpm_pkg::OP_CLEAN;
    end
  end

  logic any_flush;
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pfpm_pkg::S_IDLE;
      out_valid   <= 1'b0;
      reads_done  <= '0;
      writes_done <= '0;
      cnt         <= '0;
      any_flush   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        pfpm_pkg::S_IDLE: begin
          cnt <= '0;
          any_flush <= 1'b0;
          if (in_valid && !in_stall) begin
            cmd_q <= cmd;
            key   <= page_number;
          end
        end
        pfpm_pkg::S_SCAN: cnt <= cnt + 1'b1;
        pfpm_pkg::S_ACT: begin
          out_valid      <= 1'b1;
          last           <= 1'b1;
          fetch          <= 1'b0;
          writeback      <= 1'b0;
          writeback_page <= '0;
          frame_index    <= 3'd0;
          status         <= pfpm_pkg::ST_OK;
          read_count     <= reads_done;
          write_count    <= writes_done;
          case (cmd_q)
            pfpm_pkg::CMD_PIN: begin
              if (!found) status <= pfpm_pkg::ST_ALL_PIN;
              else begin
                frame_index <= 3'(tgt);
                if (!hit) begin
                  fetch <= 1'b1;
                  if (reads_done != '1) begin
                    reads_done <= reads_done + 1'b1;
                    read_count <= reads_done + 1'b1;
                  end
                  if (vl[tgt] && dt[tgt]) begin
                    writeback      <= 1'b1;
                    writeback_page <= pg[tgt];
                    if (writes_done != '1) begin
                      writes_done <= writes_done + 1'b1;
                      write_count <= writes_done + 1'b1;
                    end
                  end
                end
              end
            end
            pfpm_pkg::CMD_UNPIN, pfpm_pkg::CMD_DIRTY, pfpm_pkg::CMD_FORCE: begin
              if (!hit) status <= pfpm_pkg::ST_MISSING;
              else begin
                frame_index <= 3'(tgt);
                if (cmd_q == pfpm_pkg::CMD_FORCE && dt[tgt] && !pn[tgt]) begin
                  writeback      <= 1'b1;
                  writeback_page <= pg[tgt];
                  if (writes_done != '1) begin
                    writes_done <= writes_done + 1'b1;
                    write_count <= writes_done + 1'b1;
                  end
                end
              end
            end
            default: begin
              read_count  <= '0;
              write_count <= '0;
            end
          endcase
        end
        pfpm_pkg::S_FLUSH: begin
          if (!out_valid || !out_stall) begin
            cnt <= cnt + 1'b1;
            if (flush_hit || (cnt == flush_done - 1'b1 && !any_flush)) begin
              any_flush      <= 1'b1;
              out_valid      <= 1'b1;
              status         <= pfpm_pkg::ST_OK;
              fetch          <= 1'b0;
              read_count     <= reads_done;
              last           <= flush_hit ? !more_after : 1'b1;
              writeback      <= flush_hit;
              frame_index    <= flush_hit ? 3'(fidx) : 3'd0;
              writeback_page <= flush_hit ? pg[fidx] : '0;
              write_count    <= writes_done;
              if (flush_hit && writes_done != '1) begin
                writes_done <= writes_done + 1'b1;
                write_count <= writes_done + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: sv/pfpm_cell.sv
// Frame cell: one frame's state plus its link in the lookup and victim chains
module pfpm_cell #(
  parameter int PageBits = pfpm_pkg::PageBitsDef,
  parameter int IdxBits  = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IdxBits-1:0]  my_index,
  input  logic                managed,
  input  logic [PageBits-1:0] key,
  input  logic                scan,
  // chain inputs from the lower neighbour
  input  logic                hit_in,
  input  logic [IdxBits-1:0]  hit_idx_in,
  input  logic                empty_in,
  input  logic [IdxBits-1:0]  empty_idx_in,
  input  logic                cand_in,
  input  logic [IdxBits-1:0]  cand_idx_in,
  input  logic [IdxBits-1:0]  cand_rank_in,
  output logic                hit_out,
  output logic [IdxBits-1:0]  hit_idx_out,
  output logic                empty_out,
  output logic [IdxBits-1:0]  empty_idx_out,
  output logic                cand_out,
  output logic [IdxBits-1:0]  cand_idx_out,
  output logic [IdxBits-1:0]  cand_rank_out,
  // action
  input  logic                sel,
  input  pfpm_pkg::op_t       op,
  input  logic                age_upd,
  input  logic [IdxBits-1:0]  age_ref,
  output logic [PageBits-1:0] page,
  output logic                valid,
  output logic                dirty,
  output logic                pinned,
  output logic [IdxBits-1:0]  rank
);
  logic [7:0] pins;
  logic       match;

  assign pinned = (pins != 8'd0);
  assign match  = managed && valid && (page == key);

  // registered chain links, refreshed while scanning
  always_ff @(posedge clk) begin
    if (scan) begin
      hit_out     <= hit_in | match;
      hit_idx_out <= hit_in ? hit_idx_in : my_index;
      empty_out   <= empty_in | (managed && !valid);
      empty_idx_out <= empty_in ? empty_idx_in : my_index;
      if (managed && !pinned && (!cand_in || rank < cand_rank_in)) begin
        cand_out      <= 1'b1;
        cand_idx_out  <= my_index;
        cand_rank_out <= rank;
      end else begin
        cand_out      <= cand_in;
        cand_idx_out  <= cand_idx_in;
        cand_rank_out <= cand_rank_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page  <= '0;
      valid <= 1'b0;
      dirty <= 1'b0;
      pins  <= 8'd0;
      rank  <= my_index;
    end else begin
      if (age_upd) begin
        if (sel) rank <= '1;
        else if (rank > age_ref) rank <= rank - 1'b1;
      end
      if (sel) begin
        case (op)
          pfpm_pkg::OP_PIN:   if (pins != 8'hFF) pins <= pins + 8'd1;
          pfpm_pkg::OP_UNPIN: if (pins != 8'd0) pins <= pins - 8'd1;
          pfpm_pkg::OP_DIRTY: dirty <= 1'b1;
          pfpm_pkg::OP_CLEAN: dirty <= 1'b0;
          pfpm_pkg::OP_LOAD: begin
            page  <= key;
            valid <= 1'b1;
            dirty <= 1'b0;
            pins  <= 8'd1;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// File: sv/pfpm_checker.sv
// Checker: port-level properties of the page frame pool manager
module pfpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        fetch,
  input logic        writeback,
  input logic [31:0] read_count
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result waits");
  a_fetch_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fetch |-> status == 2'd0) else $error("fetch on failure");
  a_wb_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && writeback |-> status == 2'd0) else $error("writeback on failure");
  a_reads: assert property (@(posedge clk) disable iff (rst)
    out_valid && fetch && read_count != 32'hFFFFFFFF |-> read_count != 32'd0)
    else $error("fetch not counted");
endmodule

bind page_frame_pool_manager pfpm_checker u_pfpm_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .fetch, .writeback, .read_count
);

// File: tb/tb_top.sv
// Testbench: page frame pool manager, scoreboard-checked against a behavioural predictor
`timescale 1ns / 100ps

class pool_scoreboard;
  logic [23:0] fpage [8];
  bit          fvalid [8];
  bit          fdirty [8];
  int unsigned pins [8];
  int unsigned rank [8];
  logic [31:0] reads;
  logic [31:0] writes;
  bit          lru;
  int unsigned nframes;
  logic [95:0] pending [$];
  int          errors;

  function new();
    for (int i = 0; i < 8; i++) begin
      fpage[i] = '0; fvalid[i] = 0; fdirty[i] = 0; pins[i] = 0; rank[i] = i;
    end
    reads = '0; writes = '0; lru = 0; nframes = 8; errors = 0;
  endfunction

  function void set_mode(bit m);
    lru = m;
  endfunction

  function void set_frames(logic [3:0] v);
    nframes = (v == 0) ? 1 : (v > 8 ? 8 : v);
  endfunction

  function void refresh(int f);
    int unsigned r;
    r = rank[f];
    for (int i = 0; i < 8; i++) if (rank[i] > r) rank[i]--;
    rank[f] = 7;
  endfunction

  function void bump_writes();
    if (writes != 32'hFFFF_FFFF) writes++;
  endfunction

  function void push(logic [1:0] st, int fr, bit fe, bit wb, logic [23:0] wp, bit lst);
    pending.push_back({st, 3'(fr), fe, wb, wp, reads, writes, lst});
  endfunction

  function void note_request(logic [2:0] c, logic [23:0] pg);
    int f, k;
    f = -1;
    for (int i = 0; i < nframes; i++)
      if (f < 0 && fvalid[i] && fpage[i] == pg) f = i;
    case (c)
      pfpm_pkg::CMD_PIN: begin
        if (f >= 0) begin
          if (pins[f] != 255) pins[f]++;
          if (lru) refresh(f);
          push(pfpm_pkg::ST_OK, f, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < nframes; i++) if (f < 0 && !fvalid[i]) f = i;
          if (f < 0)
            for (int i = 0; i < nframes; i++)
              if (pins[i] == 0 && (f < 0 || rank[i] < rank[f])) f = i;
          if (f < 0) push(pfpm_pkg::ST_ALL_PIN, 0, 0, 0, 0, 1);
          else begin
            bit wb;
            logic [23:0] old;
            wb = fvalid[f] && fdirty[f];
            old = wb ? fpage[f] : '0;
            if (wb) bump_writes();
            if (reads != 32'hFFFF_FFFF) reads++;
            fpage[f] = pg; fvalid[f] = 1; fdirty[f] = 0; pins[f] = 1;
            refresh(f);
            push(pfpm_pkg::ST_OK, f, 1, wb, old, 1);
          end
        end
      end
      pfpm_pkg::CMD_UNPIN, pfpm_pkg::CMD_DIRTY, pfpm_pkg::CMD_FORCE: begin
        if (f < 0) push(pfpm_pkg::ST_MISSING, 0, 0, 0, 0, 1);
        else if (c == pfpm_pkg::CMD_UNPIN) begin
          if (pins[f] != 0) pins[f]--;
          push(pfpm_pkg::ST_OK, f, 0, 0, 0, 1);
        end else if (c == pfpm_pkg::CMD_DIRTY) begin
          fdirty[f] = 1;
          push(pfpm_pkg::ST_OK, f, 0, 0, 0, 1);
        end else if (fdirty[f] && pins[f] == 0) begin
          fdirty[f] = 0;
          bump_writes();
          push(pfpm_pkg::ST_OK, f, 0, 1, fpage[f], 1);
        end else push(pfpm_pkg::ST_OK, f, 0, 0, 0, 1);
      end
      pfpm_pkg::CMD_FLUSH: begin
        k = 0;
        for (int i = 0; i < nframes; i++)
          if (fvalid[i] && fdirty[i] && pins[i] == 0) begin
            fdirty[i] = 0;
            bump_writes();
            if (k > 0) pending[$][0] = 0;
            push(pfpm_pkg::ST_OK, i, 0, 1, fpage[i], 1);
            k++;
          end
        if (k == 0) push(pfpm_pkg::ST_OK, 0, 0, 0, 0, 1);
      end
      default: pending.push_back({2'd0, 3'd0, 1'b0, 1'b0, 24'd0, 32'd0, 32'd0, 1'b1});
    endcase
  endfunction

  function void check_result(logic [1:0] st, logic [2:0] fr, logic fe, logic wb,
                             logic [23:0] wp, logic [31:0] rc, logic [31:0] wc, logic lst);
    logic [95:0] e;
    if (pending.size() == 0) begin
      $error("unexpected result: status %0d frame %0d", st, fr);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[95:94] !== st) begin $error("status exp %0d got %0d", e[95:94], st); errors++; end
    if (e[93:91] !== fr) begin $error("frame_index exp %0d got %0d", e[93:91], fr); errors++; end
    if (e[90] !== fe) begin $error("fetch exp %0d got %0d", e[90], fe); errors++; end
    if (e[89] !== wb) begin $error("writeback exp %0d got %0d", e[89], wb); errors++; end
    if (e[88:65] !== wp) begin
      $error("writeback_page exp %0h got %0h", e[88:65], wp); errors++;
    end
    if (e[64:33] !== rc) begin $error("read_count exp %0d got %0d", e[64:33], rc); errors++; end
    if (e[32:1] !== wc) begin $error("write_count exp %0d got %0d", e[32:1], wc); errors++; end
    if (e[0] !== lst) begin $error("last exp %0d got %0d", e[0], lst); errors++; end
  endfunction
endclass

module tb_top;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [23:0] page_number = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [2:0]  frame_index;
  logic        fetch, writeback, last;
  logic [23:0] writeback_page;
  logic [31:0] read_count, write_count;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pool_scoreboard frame_table;
  int          idle_pct = 31;
  int          hold_off = 0;
  longint      cycles = 0;
  logic [23:0] hot_pages [6];

  page_frame_pool_manager i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      frame_table.check_result(status, frame_index, fetch, writeback, writeback_page,
                               read_count, write_count, last);

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == pfpm_pkg::REG_MODE) frame_table.set_mode(val[0]);
    else frame_table.set_frames(val[3:0]);
  endtask

  task automatic send(logic [2:0] c, logic [23:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; cmd <= c; page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_table.note_request(c, pg);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (frame_table.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r;
    logic [23:0] pg;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      pg = ($urandom_range(9) < 8) ? hot_pages[$urandom_range(5)] : 24'($urandom);
      if (r < 40) send(pfpm_pkg::CMD_PIN, pg);
      else if (r < 60) send(pfpm_pkg::CMD_UNPIN, pg);
      else if (r < 75) send(pfpm_pkg::CMD_DIRTY, pg);
      else if (r < 87) send(pfpm_pkg::CMD_FORCE, pg);
      else if (r < 96) send(pfpm_pkg::CMD_FLUSH, 24'($urandom));
      else send(3'($urandom_range(7, 5)), pg);
    end
  endtask

  initial begin
    frame_table = new();
    hot_pages = '{24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h000001, 24'h800000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: fill, dirty, overflow, flush, odd commands
    for (int i = 0; i < 8; i++) send(pfpm_pkg::CMD_PIN, 24'h100 + i);
    send(pfpm_pkg::CMD_PIN, 24'h100);
    send(pfpm_pkg::CMD_PIN, 24'hFFFFFF);
    send(pfpm_pkg::CMD_DIRTY, 24'h101);
    send(pfpm_pkg::CMD_DIRTY, 24'h102);
    send(pfpm_pkg::CMD_UNPIN, 24'h101);
    send(pfpm_pkg::CMD_UNPIN, 24'h101);
    send(pfpm_pkg::CMD_FORCE, 24'h102);
    send(pfpm_pkg::CMD_FORCE, 24'h101);
    send(pfpm_pkg::CMD_DIRTY, 24'h101);
    send(pfpm_pkg::CMD_FLUSH, 24'h0);
    send(pfpm_pkg::CMD_FORCE, 24'h7);
    send(pfpm_pkg::CMD_PIN, 24'h000000);
    send(pfpm_pkg::CMD_PIN, 24'h123456);
    send(3'd5, 24'h1);
    send(3'd7, 24'hFFFFFF);
    drain();
    write_reg(pfpm_pkg::REG_MODE, 32'd1);
    write_reg(pfpm_pkg::REG_FRAMES, 32'd1);
    idle_pct = 0;
    random_phase(40);
    drain();
    write_reg(pfpm_pkg::REG_FRAMES, 32'd0);
    idle_pct = 31;
    random_phase(30);
    drain();
    write_reg(pfpm_pkg::REG_MODE, 32'd0);
    write_reg(pfpm_pkg::REG_FRAMES, 32'd15);
    hold_off = 300;
    random_phase(90);
    drain();
    write_reg(pfpm_pkg::REG_MODE, 32'd1);
    write_reg(pfpm_pkg::REG_FRAMES, 32'd3);
    random_phase(70);
    drain();
    if (frame_table.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// File: filelist.f
sv/pfpm_pkg.sv
sv/pfpm_cell.sv
sv/page_frame_pool_manager.sv
sv/pfpm_checker.sv
tb/tb_top.sv
